[rtl/core/policy_ordered_job_queue_assert.svh]
// ----------------------------------------------------------------------------
// policy_ordered_job_queue assertion macros
// Shared property wrappers. Each one is clocked on i_clk and is held off
// during reset through i_rst_n.
// ----------------------------------------------------------------------------
`ifndef POLICY_ORDERED_JOB_QUEUE_ASSERT_SVH
`define POLICY_ORDERED_JOB_QUEUE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define POJQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies an expression in the next cycle
`define POJQ_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

[rtl/core/pojq_pkg.sv]
// ----------------------------------------------------------------------------
// pojq_pkg
// Types, codes and sizes shared by the job queue, its cells and its checker.
// ----------------------------------------------------------------------------
package pojq_pkg;

    // Queue size and derived widths
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PASS_W      = $clog2(QUEUE_DEPTH);
    localparam int SUM_W       = 16 + $clog2(QUEUE_DEPTH + 1);

    localparam logic [19:0] WAIT_MAX = 20'hFFFFF;

    // Command codes
    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_REORDER = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;
    localparam logic [1:0] CMD_REMOVE  = 2'd3;

    // Reorder policy codes
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRI  = 2'd2;

    // Cell operation codes
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_SORT  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  job_id;
        logic [15:0] run_time;
        logic [7:0]  priority_req;
        logic [1:0]  policy;
    } t_job_in;

    typedef struct packed {
        logic [4:0]  held_jobs;
        logic [7:0]  head_id;
        logic [15:0] head_cpu_time;
        logic        head_running;
        logic [19:0] expected_wait;
        logic        error;
    } t_job_out;

    // One stored job
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] cpu;
        logic [7:0]  pri;
    } t_entry;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic [1:0] op;
        logic       by_pri;
        logic       pair_l;
        logic       pair_r;
    } t_cell_ctl;

endpackage

[rtl/core/pojq_cell.sv]
// ----------------------------------------------------------------------------
// pojq_cell
// One queue slot. Loads a new job, takes its right neighbor's job on a
// head removal, or performs a stable compare-exchange with a neighbor.
// ----------------------------------------------------------------------------
module pojq_cell
    import pojq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry
);

    t_entry      r_entry;
    t_entry      n_entry;
    logic [15:0] w_key_self;
    logic [15:0] w_key_left;
    logic [15:0] w_key_right;
    logic        w_swap_l;
    logic        w_swap_r;

    // Select sort key
    assign w_key_self  = i_ctl.by_pri ? {8'd0, r_entry.pri} : r_entry.cpu;
    assign w_key_left  = i_ctl.by_pri ? {8'd0, i_left.pri}  : i_left.cpu;
    assign w_key_right = i_ctl.by_pri ? {8'd0, i_right.pri} : i_right.cpu;

    // Exchange only on strictly greater keys, so equal keys keep their order
    assign w_swap_r = i_ctl.pair_r && (w_key_self > w_key_right);
    assign w_swap_l = i_ctl.pair_l && (w_key_left > w_key_self);

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_LOAD: begin
                n_entry = i_new;
            end
            OP_SHIFT: begin
                n_entry = i_right;
            end
            OP_SORT: begin
                if (w_swap_r) begin
                    n_entry = i_right;
                end else if (w_swap_l) begin
                    n_entry = i_left;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[rtl/core/policy_ordered_job_queue.sv]
// ----------------------------------------------------------------------------
// policy_ordered_job_queue
// Bounded job queue held in a row of slot cells. Reorder runs an odd-even
// transposition sort across the cells, one pass per cycle.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_job_in)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (t_job_out)
//
// Append, start, remove and a reorder that moves nothing go from idle to the done
// state, which registers the result. A sorting reorder first runs QUEUE_DEPTH
// passes in the sort state, one per cycle, then goes to done the same way.
// One transaction is in flight at a time; o_in_ready is high only when idle.
// Reset clears count, running flag, sum and handshake state; slots need none.
// A stalled result holds in the output register; the next one waits behind it.
// ----------------------------------------------------------------------------
module policy_ordered_job_queue
    import pojq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_job_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_job_out o_out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state,  n_state;
    logic [PASS_W-1:0] r_pass,   n_pass;
    logic              r_by_pri, n_by_pri;
    logic              r_first,  n_first;
    logic              r_err,    n_err;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_run,    n_run;
    logic [SUM_W-1:0]  r_sum,    n_sum;
    logic              r_out_valid, n_out_valid;
    t_job_out          r_out;
    t_job_out          w_result;

    logic              w_fire;
    logic              w_full;
    logic              w_empty;
    logic              w_first;
    logic              w_load_out;
    logic [QUEUE_DEPTH-1:0] w_pair;

    t_entry    w_entry [QUEUE_DEPTH];
    t_cell_ctl w_ctl   [QUEUE_DEPTH];
    t_entry    w_new;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_first    = r_run && !w_empty;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign w_new.id  = i_in_data.job_id;
    assign w_new.cpu = i_in_data.run_time;
    assign w_new.pri = i_in_data.priority_req;

    // Enable compare-exchange pairs of this pass inside the waiting range
    always_comb begin
        w_pair = '0;
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            w_pair[k] = (1'(k) == r_pass[0]) && ((k != 0) || !r_first) &&
                        (CNT_W'(k + 1) < r_count);
        end
    end

    // Drive per-cell control
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_ctl[k].op     = OP_HOLD;
            w_ctl[k].by_pri = r_by_pri;
            w_ctl[k].pair_r = (k < QUEUE_DEPTH - 1) ? w_pair[k] : 1'b0;
            w_ctl[k].pair_l = (k > 0) ? w_pair[(k > 0) ? k - 1 : 0] : 1'b0;
            if (r_state == ST_SORT) begin
                w_ctl[k].op = OP_SORT;
            end else if (w_fire) begin
                case (i_in_data.command)
                    CMD_APPEND: begin
                        if (!w_full && (r_count == CNT_W'(k))) begin
                            w_ctl[k].op = OP_LOAD;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!w_empty) begin
                            w_ctl[k].op = OP_SHIFT;
                        end
                    end
                    default: begin
                        w_ctl[k].op = OP_HOLD;
                    end
                endcase
            end
        end
    end

    // Row of slot cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        pojq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_new   (w_new),
            .i_left  (w_entry[(g > 0) ? g - 1 : g]),
            .i_right (w_entry[(g < QUEUE_DEPTH - 1) ? g + 1 : g]),
            .o_entry (w_entry[g])
        );
    end

    // Sequence commands and track count, running flag and CPU time sum
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_by_pri    = r_by_pri;
        n_first     = r_first;
        n_err       = r_err;
        n_count     = r_count;
        n_run       = r_run;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    n_err   = 1'b0;
                    n_state = ST_DONE;
                    case (i_in_data.command)
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                n_sum   = r_sum + SUM_W'(i_in_data.run_time);
                            end
                        end
                        CMD_REORDER: begin
                            if (((i_in_data.policy == POL_SJF) ||
                                 (i_in_data.policy == POL_PRI)) &&
                                (r_count >= CNT_W'(2) + CNT_W'(w_first))) begin
                                n_state  = ST_SORT;
                                n_pass   = '0;
                                n_by_pri = (i_in_data.policy == POL_PRI);
                                n_first  = w_first;
                            end
                        end
                        CMD_START: begin
                            if (w_empty) begin
                                n_err = 1'b1;
                            end else begin
                                n_run = 1'b1;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                n_run   = 1'b0;
                                n_sum   = r_sum - SUM_W'(w_entry[0].cpu);
                            end
                        end
                    endcase
                end
            end
            ST_SORT: begin
                n_pass = r_pass + PASS_W'(1);
                if (r_pass == PASS_W'(QUEUE_DEPTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= '0;
            r_by_pri    <= 1'b0;
            r_first     <= 1'b0;
            r_err       <= 1'b0;
            r_count     <= '0;
            r_run       <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_by_pri    <= n_by_pri;
            r_first     <= n_first;
            r_err       <= n_err;
            r_count     <= n_count;
            r_run       <= n_run;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Build the result from the settled state
    always_comb begin
        w_result.held_jobs     = 5'(r_count);
        w_result.head_id       = w_empty ? 8'd0 : w_entry[0].id;
        w_result.head_cpu_time = w_empty ? 16'd0 : w_entry[0].cpu;
        w_result.head_running  = w_first;
        w_result.expected_wait = (r_sum > SUM_W'(WAIT_MAX)) ? WAIT_MAX : 20'(r_sum);
        w_result.error         = r_err;
    end

    // Capture the result when the done state loads the output, and hold it until the next load
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/pojq_checker.sv]
// ----------------------------------------------------------------------------
// pojq_checker
// Port-level checks on the job queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "policy_ordered_job_queue_assert.svh"

module pojq_checker
    import pojq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_job_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_job_out o_out_data
);

    logic w_in_fire;
    logic w_empty_rpt;
    logic w_zero_head;
    logic w_err_rpt;
    logic w_at_bound;

    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_empty_rpt = o_out_valid && (o_out_data.held_jobs == 5'd0);
    assign w_zero_head = (o_out_data.head_id == 8'd0) &&
                         (o_out_data.head_cpu_time == 16'd0) &&
                         !o_out_data.head_running &&
                         (o_out_data.expected_wait == 20'd0);
    assign w_err_rpt   = o_out_valid && o_out_data.error;
    assign w_at_bound  = (o_out_data.held_jobs == 5'd0) ||
                         (o_out_data.held_jobs == 5'(QUEUE_DEPTH));

    // Stalled result stays valid
    `POJQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    // One transaction at a time: no acceptance right after an acceptance
    `POJQ_ASSERT_NEXT(a_one_in_flight, w_in_fire, !o_in_ready, "back-to-back acceptance")

    // Empty queue reports a zero head and zero sum
    `POJQ_ASSERT(a_empty_head, w_empty_rpt |-> w_zero_head, "empty queue reports a job")

    // Errors only occur on an empty or a full queue
    `POJQ_ASSERT(a_error_bound, w_err_rpt |-> w_at_bound, "error on a partly filled queue")

endmodule

bind policy_ordered_job_queue pojq_checker u_pojq_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// policy_ordered_job_queue testbench
// Sends job commands to the queue and checks every status result. The
// expected status comes from a queue model kept inside the bench: it stores
// the held jobs, sorts the waiting ones by shortest job first or by priority,
// and keeps the running head in place. The run has a directed part first.
// This part hits empty and full errors, both sort policies, the spare policy
// code and a running head. A random part follows, with phases that fill and drain the queue.
// Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import pojq_pkg::*;

    localparam int RANDOM_JOBS     = 1000;
    localparam int PHASE_LEN       = 40;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = QUEUE_DEPTH + 8;

    // Policy code with no sort rule of its own
    localparam logic [1:0] POL_SPARE = 2'd3;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_job_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_job_out o_out_data;

    // Jobs waiting to be sent and status results waiting to arrive
    t_job_in     command_backlog[$];
    t_job_out    expected_status[$];

    // Queue model state
    t_entry      model_slots[QUEUE_DEPTH];
    int unsigned model_count   = 0;
    logic        model_running = 1'b0;

    // Run bookkeeping
    int unsigned jobs_queued     = 0;
    int unsigned jobs_accepted   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned error_cases     = 0;
    int unsigned full_hits       = 0;
    int unsigned sort_moves      = 0;
    int unsigned cmd_seen[4]     = '{0, 0, 0, 0};
    bit          in_accepted     = 1'b0;
    bit          hold_off        = 1'b0;
    int unsigned send_gap        = 0;
    int unsigned send_burst      = 0;
    int unsigned recv_stall      = 0;
    int unsigned recv_burst      = 0;

    policy_ordered_job_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock generator
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long, with runs of no idling
    function automatic int unsigned pick_gap(inout int unsigned burst_left);
        int unsigned roll;
        if (burst_left > 0) begin
            burst_left--;
            pick_gap = 0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                burst_left = $urandom_range(20, 80);
                pick_gap   = 0;
            end else if (roll < 60) begin
                pick_gap = 0;
            end else if (roll < 92) begin
                pick_gap = $urandom_range(1, 3);
            end else begin
                pick_gap = $urandom_range(10, 50);
            end
        end
    endfunction

    // Apply one command to the queue model and return the status it yields
    function automatic t_job_out apply_job_command(t_job_in job);
        t_job_out    status;
        t_entry      key;
        int unsigned first;
        int unsigned pos;
        int unsigned idx;
        logic [31:0] total;
        logic        by_cpu;
        status = '0;
        case (job.command)
            CMD_APPEND: begin
                if (model_count >= QUEUE_DEPTH) begin
                    status.error = 1'b1;
                end else begin
                    model_slots[model_count] = '{id: job.job_id, cpu: job.run_time,
                                                 pri: job.priority_req};
                    model_count++;
                end
            end
            CMD_REORDER: begin
                // Keep a running head out of the sort
                first  = (model_count > 0 && model_running) ? 1 : 0;
                by_cpu = (job.policy == POL_SJF);
                if ((job.policy == POL_SJF || job.policy == POL_PRI) &&
                        model_count >= first + 2) begin
                    // Stable insertion: only strictly larger keys move back
                    for (idx = first + 1; idx < model_count; idx++) begin
                        key = model_slots[idx];
                        pos = idx;
                        while (pos > first &&
                                ((by_cpu && model_slots[pos-1].cpu > key.cpu) ||
                                 (!by_cpu && model_slots[pos-1].pri > key.pri))) begin
                            model_slots[pos] = model_slots[pos-1];
                            pos--;
                        end
                        if (pos != idx) begin
                            sort_moves++;
                        end
                        model_slots[pos] = key;
                    end
                end
            end
            CMD_START: begin
                if (model_count == 0) begin
                    status.error = 1'b1;
                end else begin
                    model_running = 1'b1;
                end
            end
            default: begin
                if (model_count == 0) begin
                    status.error = 1'b1;
                end else begin
                    for (idx = 1; idx < model_count; idx++) begin
                        model_slots[idx-1] = model_slots[idx];
                    end
                    model_count--;
                    model_running = 1'b0;
                end
            end
        endcase

        total = '0;
        for (idx = 0; idx < model_count; idx++) begin
            total += 32'(model_slots[idx].cpu);
        end
        status.held_jobs     = model_count[4:0];
        status.head_id       = (model_count > 0) ? model_slots[0].id : '0;
        status.head_cpu_time = (model_count > 0) ? model_slots[0].cpu : '0;
        status.head_running  = (model_count > 0) && model_running;
        status.expected_wait = (total > 32'(WAIT_MAX)) ? WAIT_MAX : total[19:0];
        return status;
    endfunction

    // Report one status field that differs from the model
    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_checked, field, want, got);
            end
        end
    endtask

    task automatic compare_status(t_job_out want, t_job_out got);
        check_field("held_jobs", 32'(want.held_jobs), 32'(got.held_jobs));
        check_field("head_id", 32'(want.head_id), 32'(got.head_id));
        check_field("head_cpu_time", 32'(want.head_cpu_time), 32'(got.head_cpu_time));
        check_field("head_running", 32'(want.head_running), 32'(got.head_running));
        check_field("expected_wait", 32'(want.expected_wait), 32'(got.expected_wait));
        check_field("error", 32'(want.error), 32'(got.error));
    endtask

    task automatic queue_job(t_job_in job);
        command_backlog.push_back(job);
        jobs_queued++;
    endtask

    function automatic t_job_in make_job(logic [1:0] cmd, logic [7:0] id,
                                         logic [15:0] cpu, logic [7:0] pri,
                                         logic [1:0] pol);
        make_job = '{command: cmd, job_id: id, run_time: cpu,
                     priority_req: pri, policy: pol};
    endfunction

    // Random job; bias picks a fill, drain or balanced command mix
    function automatic t_job_in random_job(int unsigned bias);
        t_job_in     job;
        int unsigned roll;
        job.job_id = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            job.run_time = 16'($urandom_range(0, 65535));
        end else if (roll < 80) begin
            job.run_time = 16'($urandom_range(0, 7));
        end else begin
            job.run_time = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        job.priority_req = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            job.policy = POL_SJF;
        end else if (roll < 80) begin
            job.policy = POL_PRI;
        end else if (roll < 90) begin
            job.policy = POL_FCFS;
        end else begin
            job.policy = POL_SPARE;
        end
        roll = $urandom_range(0, 99);
        case (bias)
            0: begin
                job.command = (roll < 60) ? CMD_APPEND : (roll < 75) ? CMD_REORDER :
                              (roll < 85) ? CMD_START : CMD_REMOVE;
            end
            1: begin
                job.command = (roll < 15) ? CMD_APPEND : (roll < 30) ? CMD_REORDER :
                              (roll < 45) ? CMD_START : CMD_REMOVE;
            end
            default: begin
                job.command = (roll < 35) ? CMD_APPEND : (roll < 60) ? CMD_REORDER :
                              (roll < 75) ? CMD_START : CMD_REMOVE;
            end
        endcase
        return job;
    endfunction

    // Wait until every queued job is accepted and every result has come
    task automatic wait_until_drained();
        while (jobs_accepted != jobs_queued || expected_status.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: present the next job at the falling edge once the last one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_accepted)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (command_backlog.size() > 0) begin
                i_in_data  <= command_backlog.pop_front();
                i_in_valid <= 1'b1;
                send_gap    = pick_gap(send_burst);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, and hold off entirely while hold_off is set
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            recv_stall   = pick_gap(recv_burst);
        end
    end

    // Monitor: check results and predict each accepted transaction
    always @(posedge i_clk) begin : monitor
        t_job_out want;
        if (!i_rst_n) begin
            in_accepted = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result 0x%0h with nothing pending",
                                 o_out_data);
                    end
                end else begin
                    want = expected_status.pop_front();
                    compare_status(want, o_out_data);
                end
                results_checked++;
            end
            in_accepted = i_in_valid && o_in_ready;
            if (in_accepted) begin
                if (i_in_data.command == CMD_APPEND && model_count >= QUEUE_DEPTH) begin
                    full_hits++;
                end
                want = apply_job_command(i_in_data);
                expected_status.push_back(want);
                if (want.error) begin
                    error_cases++;
                end
                cmd_seen[i_in_data.command]++;
                jobs_accepted++;
            end
        end
    end

    // Long output stall while the sender keeps going, to back up the input
    initial begin
        while (jobs_accepted < HOLD_OFF_AT) begin
            @(posedge i_clk);
        end
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Stimulus and end of run
    initial begin : stimulus
        int unsigned n;
        int unsigned bias;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: errors on start and remove, reorder does nothing
        queue_job(make_job(CMD_REMOVE, 8'h00, 16'h0000, 8'h00, POL_FCFS));
        queue_job(make_job(CMD_START, 8'hFF, 16'hFFFF, 8'hFF, POL_SPARE));
        queue_job(make_job(CMD_REORDER, 8'h00, 16'h0000, 8'h00, POL_SJF));
        // Fill to one short of full, extremes first, then ties on both keys
        queue_job(make_job(CMD_APPEND, 8'h00, 16'h0000, 8'h00, POL_FCFS));
        queue_job(make_job(CMD_APPEND, 8'hFF, 16'hFFFF, 8'hFF, POL_FCFS));
        for (n = 2; n < QUEUE_DEPTH - 1; n++) begin
            queue_job(make_job(CMD_APPEND, 8'(n * 17), 16'((n % 4) * 100),
                               8'((QUEUE_DEPTH - n) % 5), POL_FCFS));
        end
        // Start the head, append while it runs, then overflow
        queue_job(make_job(CMD_START, 8'h00, 16'h0000, 8'h00, POL_FCFS));
        queue_job(make_job(CMD_APPEND, 8'hA5, 16'h0001, 8'h02, POL_FCFS));
        queue_job(make_job(CMD_APPEND, 8'h5A, 16'h0002, 8'h01, POL_FCFS));
        // Unused policy, sort around the running head, start again, priority sort, then pop and sort
        queue_job(make_job(CMD_REORDER, 8'h00, 16'h0000, 8'h00, POL_SPARE));
        queue_job(make_job(CMD_REORDER, 8'h00, 16'h0000, 8'h00, POL_SJF));
        queue_job(make_job(CMD_START, 8'h00, 16'h0000, 8'h00, POL_FCFS));
        queue_job(make_job(CMD_REORDER, 8'h00, 16'h0000, 8'h00, POL_PRI));
        queue_job(make_job(CMD_REMOVE, 8'h00, 16'h0000, 8'h00, POL_FCFS));
        queue_job(make_job(CMD_REORDER, 8'h00, 16'h0000, 8'h00, POL_SJF));
        wait_until_drained();

        // Random part in two halves, with the sender paused in between
        bias = 0;
        for (n = 0; n < RANDOM_JOBS; n++) begin
            if (n % PHASE_LEN == 0) begin
                bias = $urandom_range(0, 2);
            end
            queue_job(random_job(bias));
            if (n == RANDOM_JOBS / 2) begin
                wait_until_drained();
            end
        end
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("checked %0d results over %0d commands: %0d append, %0d reorder,",
                 results_checked, jobs_accepted, cmd_seen[CMD_APPEND],
                 cmd_seen[CMD_REORDER]);
        $display("%0d start, %0d remove, %0d error cases (%0d full), %0d sort moves",
                 cmd_seen[CMD_START], cmd_seen[CMD_REMOVE], error_cases, full_hits,
                 sort_moves);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("policy_ordered_job_queue regression: pass");
        end else begin
            $display("policy_ordered_job_queue regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("timeout with %0d results outstanding", expected_status.size());
        $display("policy_ordered_job_queue regression: fail");
        $finish;
    end

endmodule
